### src/sbrc_pkg.sv
// ----------------------------------------------------------------------------
// sbrc_pkg
// Shared types and constants for the sparse block row counter.
// ----------------------------------------------------------------------------
`default_nettype none

package sbrc_pkg;

  localparam int BLK_SIZE_W  = 7;
  localparam int NUM_COLS_W  = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int COUNT_OUT_W = 11;
  localparam int POINTER_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BLK_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

  localparam logic [BLK_SIZE_W-1:0] BLK_SIZE_RESET = 7'd4;
  localparam logic [NUM_COLS_W-1:0] NUM_COLS_RESET = 16'd4096;

  // memory port controls
  typedef struct packed {
    logic seen_rd;
    logic seen_we;
    logic seen_wbit;
    logic tl_rd;
    logic tl_we;
  } mem_ctl_t;

endpackage

`default_nettype wire

### src/sbrc_if.sv
// ----------------------------------------------------------------------------
// sbrc_if
// Valid/ready channels for input items and block row results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbrc_item_if #(
  parameter int COL_BITS = 16
);
  logic                valid;
  logic                ready;
  logic [COL_BITS-1:0] col_index;
  logic                has_entry;
  logic                block_row_end;

  modport source (output valid, output col_index, output has_entry,
                  output block_row_end, input ready);
  modport sink   (input valid, input col_index, input has_entry,
                  input block_row_end, output ready);
endinterface

interface sbrc_result_if;
  import sbrc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [COUNT_OUT_W-1:0] blocks_in_row;
  logic [POINTER_W-1:0]   row_pointer;
  logic                   column_error;

  modport source (output valid, output blocks_in_row, output row_pointer,
                  output column_error, input ready);
  modport sink   (input valid, input blocks_in_row, input row_pointer,
                  input column_error, output ready);
endinterface

`default_nettype wire

### src/sbrc_divider.sv
// ----------------------------------------------------------------------------
// sbrc_divider
// Restoring divider, one quotient bit per cycle: column over block size.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrc_divider #(
  parameter int COL_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [COL_BITS-1:0]             dividend,
  input  wire logic [sbrc_pkg::BLK_SIZE_W-1:0] divisor,
  output logic                                 done,
  output logic [COL_BITS-1:0]                  quotient
);
  import sbrc_pkg::*;

  localparam int STEP_W = $clog2(COL_BITS + 1);

  logic                  busy;
  logic [STEP_W-1:0]     steps;
  logic [BLK_SIZE_W-1:0] dvs;
  logic [BLK_SIZE_W-1:0] rem;
  logic [COL_BITS-1:0]   num;
  logic [BLK_SIZE_W:0]   rem_sh;
  logic [BLK_SIZE_W:0]   rem_sub;
  logic                  qbit;

  always_comb begin
    rem_sh  = {rem, num[COL_BITS-1]};
    qbit    = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  assign done     = busy && (steps == '0);
  assign quotient = num;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_W'(COL_BITS);
      dvs   <= divisor;
      rem   <= '0;
      num   <= dividend;
    end else if (busy) begin
      if (steps == '0) begin
        busy <= 1'b0;
      end else begin
        steps <= steps - 1'b1;
        rem   <= qbit ? rem_sub[BLK_SIZE_W-1:0] : rem_sh[BLK_SIZE_W-1:0];
        num   <= {num[COL_BITS-2:0], qbit};
      end
    end
  end

endmodule

`default_nettype wire

### src/sbrc_bitmap.sv
// ----------------------------------------------------------------------------
// sbrc_bitmap
// Seen bitmap and touched list memories, registered reads.
// ----------------------------------------------------------------------------
`default_nettype none

module sbrc_bitmap #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic                 clk,
  input  wire sbrc_pkg::mem_ctl_t   ctl,
  input  wire logic [ADDR_W-1:0]    seen_raddr,
  input  wire logic [ADDR_W-1:0]    seen_waddr,
  output logic                      seen_rbit,
  input  wire logic [ADDR_W-1:0]    tl_raddr,
  input  wire logic [ADDR_W-1:0]    tl_waddr,
  input  wire logic [ADDR_W-1:0]    tl_wdata,
  output logic [ADDR_W-1:0]         tl_rdata
);
  import sbrc_pkg::*;

  logic              seen_mem [DEPTH];
  logic [ADDR_W-1:0] tl_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.seen_we) begin
      seen_mem[seen_waddr] <= ctl.seen_wbit;
    end
    if (ctl.seen_rd) begin
      seen_rbit <= seen_mem[seen_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tl_we) begin
      tl_mem[tl_waddr] <= tl_wdata;
    end
    if (ctl.tl_rd) begin
      tl_rdata <= tl_mem[tl_raddr];
    end
  end

endmodule

`default_nettype wire

### src/sparse_block_row_counter_unit.sv
// ----------------------------------------------------------------------------
// sparse_block_row_counter_unit
// Counts distinct block columns per block row of a CSR column stream and
// emits the per-row count with a saturating running row pointer.
// ----------------------------------------------------------------------------
// entry in range: divided by the bit-serial divider, then looked up in the seen bitmap
// out-of-range entry or item without entry: taken in S_IDLE with no divide
// block row end: S_EMIT, then S_CLEAR resets each touched seen bit, one clear per cycle
// result is registered in S_EMIT and waits in an output register until taken
// after reset S_INIT clears all MAX_BLOCK_COLS bitmap entries before any item is taken
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_block_row_counter_unit #(
  parameter int MAX_BLOCK_COLS = 1024,
  parameter int COL_BITS       = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [sbrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sbrc_pkg::CFG_DATA_W-1:0] cfg_data,
  sbrc_item_if.sink                            items,
  sbrc_result_if.source                        results
);
  import sbrc_pkg::*;

  localparam int BCOL_W = $clog2(MAX_BLOCK_COLS);
  localparam int CNT_W  = $clog2(MAX_BLOCK_COLS + 1);
  localparam int CMP_W  = (COL_BITS > NUM_COLS_W) ? COL_BITS : NUM_COLS_W;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  logic [2:0]             state;
  logic [BLK_SIZE_W-1:0]  blk_size;
  logic [NUM_COLS_W-1:0]  num_cols;
  logic [CNT_W-1:0]       init_idx;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       clr_idx;
  logic                   clr_pend;
  logic [POINTER_W-1:0]   total;
  logic                   err;
  logic                   row_end;
  logic [BCOL_W-1:0]      bcol;
  logic                   out_valid;
  logic [COUNT_OUT_W-1:0] out_blocks;
  logic [POINTER_W-1:0]   out_pointer;
  logic                   out_err;

  logic [BLK_SIZE_W-1:0]  dim_eff;
  logic                   accept;
  logic                   col_bad;
  logic                   div_start;
  logic                   div_done;
  logic [COL_BITS-1:0]    quotient;
  logic [31:0]            q_ext;
  logic                   q_bad;
  logic                   emit_go;
  logic [POINTER_W:0]     sum;
  logic [POINTER_W-1:0]   total_next;
  logic [31:0]            count_ext;
  logic                   clr_issue;

  mem_ctl_t               mem_ctl;
  logic [BCOL_W-1:0]      seen_waddr;
  logic                   seen_rbit;
  logic [BCOL_W-1:0]      tl_rdata;

  assign dim_eff   = (blk_size == '0) ? BLK_SIZE_W'(1) : blk_size;
  assign accept    = items.valid && items.ready;
  assign col_bad   = CMP_W'(items.col_index) >= CMP_W'(num_cols);
  assign div_start = accept && items.has_entry && !col_bad;
  assign q_ext     = 32'(quotient);
  assign q_bad     = 33'(quotient) >= 33'(MAX_BLOCK_COLS);
  assign emit_go   = (state == S_EMIT) && (!out_valid || results.ready);
  assign sum       = {1'b0, total} + (POINTER_W + 1)'(count);
  assign total_next = sum[POINTER_W] ? '1 : sum[POINTER_W-1:0];
  assign count_ext = 32'(count);
  assign clr_issue = (state == S_CLEAR) && (clr_idx != count);

  assign items.ready           = (state == S_IDLE);
  assign results.valid         = out_valid;
  assign results.blocks_in_row = out_blocks;
  assign results.row_pointer   = out_pointer;
  assign results.column_error  = out_err;

  sbrc_divider #(
    .COL_BITS (COL_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (items.col_index),
    .divisor  (dim_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    mem_ctl.seen_rd   = (state == S_DIV) && div_done && !q_bad;
    mem_ctl.seen_we   = 1'b0;
    mem_ctl.seen_wbit = 1'b0;
    mem_ctl.tl_rd     = clr_issue;
    mem_ctl.tl_we     = 1'b0;
    seen_waddr        = bcol;
    case (state)
      S_INIT: begin
        mem_ctl.seen_we = 1'b1;
        seen_waddr      = init_idx[BCOL_W-1:0];
      end
      S_LOOK: begin
        mem_ctl.seen_we   = !seen_rbit;
        mem_ctl.seen_wbit = 1'b1;
        mem_ctl.tl_we     = !seen_rbit;
      end
      S_CLEAR: begin
        mem_ctl.seen_we = clr_pend;
        seen_waddr      = tl_rdata;
      end
      default: begin
      end
    endcase
  end

  sbrc_bitmap #(
    .DEPTH  (MAX_BLOCK_COLS),
    .ADDR_W (BCOL_W)
  ) u_bitmap (
    .clk        (clk),
    .ctl        (mem_ctl),
    .seen_raddr (q_ext[BCOL_W-1:0]),
    .seen_waddr (seen_waddr),
    .seen_rbit  (seen_rbit),
    .tl_raddr   (clr_idx[BCOL_W-1:0]),
    .tl_waddr   (count[BCOL_W-1:0]),
    .tl_wdata   (bcol),
    .tl_rdata   (tl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_size <= BLK_SIZE_RESET;
      num_cols <= NUM_COLS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BLK_SIZE: blk_size <= cfg_data[BLK_SIZE_W-1:0];
        REG_NUM_COLS: num_cols <= cfg_data[NUM_COLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_idx  <= '0;
      count     <= '0;
      clr_idx   <= '0;
      clr_pend  <= 1'b0;
      total     <= '0;
      err       <= 1'b0;
      row_end   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && results.ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_idx <= init_idx + 1'b1;
          if (init_idx == CNT_W'(MAX_BLOCK_COLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            row_end <= items.block_row_end;
            if (items.has_entry && col_bad) begin
              err <= 1'b1;
            end
            if (div_start) begin
              state <= S_DIV;
            end else if (items.block_row_end) begin
              state <= S_EMIT;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            bcol <= q_ext[BCOL_W-1:0];
            if (q_bad) begin
              err   <= 1'b1;
              state <= row_end ? S_EMIT : S_IDLE;
            end else begin
              state <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (!seen_rbit) begin
            count <= count + 1'b1;
          end
          state <= row_end ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid   <= 1'b1;
            out_blocks  <= count_ext[COUNT_OUT_W-1:0];
            out_pointer <= total_next;
            out_err     <= err;
            total       <= total_next;
            err         <= 1'b0;
            clr_idx     <= '0;
            clr_pend    <= 1'b0;
            state       <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          clr_pend <= clr_issue;
          if (clr_issue) begin
            clr_idx <= clr_idx + 1'b1;
          end else if (!clr_pend) begin
            count <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // row count never passes the bitmap depth
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BLOCK_COLS))
    else $error("row block count overflow");

  // a new result is loaded only on the way into the clearing pass
  assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> state == S_CLEAR)
    else $error("result loaded outside row close");

  // no bitmap clear write is left pending when items are taken again
  assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !clr_pend && count_ext <= 32'(MAX_BLOCK_COLS))
    else $error("clear pass unfinished in idle");

  // divider finishes only while the control waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider result outside divide state");

endmodule

`default_nettype wire
